FILE: hdl/tcr_pkg.sv
// Shared types and constants for the TCP connection tracker.
package tcr_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SEQ_W       = 32;
    localparam int LEN_W       = 16;
    localparam int TAG_W       = 16;

    typedef enum logic [2:0] {
        ST_SYN     = 3'd0,
        ST_SYNACK  = 3'd1,
        ST_EST     = 3'd2,
        ST_FIN1    = 3'd3,
        ST_FIN1ACK = 3'd4,
        ST_FIN2    = 3'd5,
        ST_CLOSE   = 3'd6
    } conn_t;

    typedef enum logic [2:0] {
        RES_OK      = 3'd0,
        RES_SEQ     = 3'd1,
        RES_RST     = 3'd2,
        RES_OVERLAP = 3'd3,
        RES_FULL    = 3'd4,
        RES_BADLEN  = 3'd5,
        RES_CLOSED  = 3'd6
    } res_t;

    typedef enum logic [1:0] {
        REG_FLOOR0 = 2'd0,
        REG_FLOOR1 = 2'd1,
        REG_START0 = 2'd2,
        REG_START1 = 2'd3
    } reg_idx_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EVAL = 1'b1
    } fsm_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        logic [TAG_W-1:0] tag;
    } entry_t;

    // new segment offered to a table; ins commits it
    typedef struct packed {
        logic             ins;
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        logic [TAG_W-1:0] tag;
    } cmd_t;

    typedef struct packed {
        logic less;
        logic ovl;
    } cell_flags_t;

endpackage

FILE: hdl/tcp_connection_tracker_reassembly_unit.sv
// Top level: TCP connection tracker with per-direction reassembly tables.
// Accepted word: evaluate/commit in EVAL, then a registered result held until taken.
// The next word is not taken during EVAL; it waits for the table commit.
// A new word is taken while the previous result is being taken on the same edge.
// Reset (rst_n, async low): state SYN, tables empty, floors and expected seqs 0.
module tcp_connection_tracker_reassembly_unit
    import tcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // seq[31:0], syn, ack, fin, rst, psh, frame_len[15:0], header_len[15:0], tag[15:0]
    input  logic [87:0] s_axis_tdata,
    // direction
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], connection_state[2:0], assembled_length[31:0], entry_count[4:0]
    output logic [47:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    fsm_t             fsm_reg, fsm_next;
    conn_t            conn_reg, conn_next;
    logic [31:0]      floor_reg   [2];
    logic [31:0]      nexp_reg    [2];
    logic [31:0]      asm_reg     [2];
    logic [31:0]      asm_next;
    logic             dir_reg;
    logic [84:0]      item_reg;
    logic             ovalid_reg, ovalid_next;
    logic [47:0]      odata_reg;
    logic [47:0]      odata_next;

    logic [31:0]      seq;
    logic             f_syn, f_ack, f_fin, f_rst, f_psh;
    logic [15:0]      flen, hlen, tag;
    logic [15:0]      size;
    logic             accept;
    logic             path_ins, do_ins, full, ovl, upd;
    res_t             status;
    cmd_t             cmd0, cmd1;
    logic [CNT_W-1:0] cnt0, cnt1, cnt;
    logic             ovl0, ovl1;
    logic [32:0]      asum;

    assign seq   = item_reg[31:0];
    assign f_syn = item_reg[32];
    assign f_ack = item_reg[33];
    assign f_fin = item_reg[34];
    assign f_rst = item_reg[35];
    assign f_psh = item_reg[36];
    assign flen  = item_reg[52:37];
    assign hlen  = item_reg[68:53];
    assign tag   = item_reg[84:69];
    assign size  = flen - hlen;

    assign s_axis_tready = (fsm_reg == FSM_IDLE) && (!ovalid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign cnt  = dir_reg ? cnt1 : cnt0;
    assign ovl  = dir_reg ? ovl1 : ovl0;
    assign full = cnt >= CNT_W'(QUEUE_DEPTH);
    assign asum = {1'b0, asm_reg[dir_reg]} + {17'd0, size};

    always_comb
    begin
        conn_next = conn_reg;
        status    = RES_OK;
        path_ins  = 1'b0;
        do_ins    = 1'b0;
        if (floor_reg[dir_reg] != 32'd0 && seq <= floor_reg[dir_reg])
            status = RES_SEQ;
        else if (f_rst)
            status = RES_RST;
        else
        begin
            unique case (conn_reg)
                ST_SYN:     if (dir_reg && f_syn && f_ack) conn_next = ST_SYNACK;
                ST_SYNACK:  if (!dir_reg && f_ack) conn_next = ST_EST;
                ST_EST:
                begin
                    if (f_fin) conn_next = ST_FIN1;
                    path_ins = f_psh;
                end
                ST_FIN1:
                begin
                    if (f_fin)
                        conn_next = ST_FIN2;
                    else if (f_ack)
                        conn_next = ST_FIN1ACK;
                    path_ins = f_psh;
                end
                ST_FIN1ACK: if (f_fin) conn_next = ST_FIN2;
                ST_FIN2:    if (f_ack) conn_next = ST_CLOSE;
                ST_CLOSE:   status = RES_CLOSED;
                default:    ;
            endcase
        end
        if (path_ins)
        begin
            priority if (hlen > flen)
                status = RES_BADLEN;
            else if (size == 16'd0)
                status = RES_OK;
            else if (full)
                status = RES_FULL;
            else if (ovl)
                status = RES_OVERLAP;
            else
                do_ins = (fsm_reg == FSM_EVAL);
        end
    end

    // in-order segment advances the expected seq and the saturating byte count
    assign upd      = do_ins && (nexp_reg[dir_reg] == seq);
    assign asm_next = upd ? (asum[32] ? 32'hFFFF_FFFF : asum[31:0]) : asm_reg[dir_reg];

    assign cmd0 = '{ins: do_ins && !dir_reg, seq: seq, len: size, tag: tag};
    assign cmd1 = '{ins: do_ins &&  dir_reg, seq: seq, len: size, tag: tag};

    tcr_chain u_chain0 (.clk(clk), .rst_n(rst_n), .cmd(cmd0), .count(cnt0), .ovl(ovl0));
    tcr_chain u_chain1 (.clk(clk), .rst_n(rst_n), .cmd(cmd1), .count(cnt1), .ovl(ovl1));

    always_comb
    begin
        fsm_next    = fsm_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        odata_next  = odata_reg;
        unique case (fsm_reg)
            FSM_IDLE: if (accept) fsm_next = FSM_EVAL;
            FSM_EVAL:
            begin
                fsm_next    = FSM_IDLE;
                ovalid_next = 1'b1;
                odata_next  = {5'd0,
                               5'(cnt + CNT_W'(do_ins)),
                               do_ins ? asm_next : 32'd0,
                               3'(conn_next), 3'(status)};
            end
            default:  fsm_next = FSM_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg      <= FSM_IDLE;
            conn_reg     <= ST_SYN;
            ovalid_reg   <= 1'b0;
            floor_reg[0] <= '0;
            floor_reg[1] <= '0;
            nexp_reg[0]  <= '0;
            nexp_reg[1]  <= '0;
            asm_reg[0]   <= '0;
            asm_reg[1]   <= '0;
        end
        else
        begin
            fsm_reg    <= fsm_next;
            ovalid_reg <= ovalid_next;
            if (fsm_reg == FSM_EVAL)
            begin
                conn_reg         <= conn_next;
                asm_reg[dir_reg] <= asm_next;
                if (upd)
                    nexp_reg[dir_reg] <= seq + {16'd0, size};
            end
            if (cfg_we)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_FLOOR0: floor_reg[0] <= cfg_data;
                    REG_FLOOR1: floor_reg[1] <= cfg_data;
                    REG_START0: nexp_reg[0]  <= cfg_data;
                    REG_START1: nexp_reg[1]  <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dir_reg  <= s_axis_tuser;
            item_reg <= s_axis_tdata[84:0];
        end
        odata_reg <= odata_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

`ifndef SYNTHESIS
    a_eval_one: assert property (@(posedge clk) disable iff (!rst_n)
        fsm_reg == FSM_EVAL |=> m_axis_tvalid && fsm_reg == FSM_IDLE)
        else $error("result not produced after evaluation");
    a_eval_free: assert property (@(posedge clk) disable iff (!rst_n)
        fsm_reg == FSM_EVAL |-> !ovalid_reg || m_axis_tready)
        else $error("result register busy at evaluation");
    a_count_rng: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[47:38] <= 10'(QUEUE_DEPTH))
        else $error("entry count out of range");
    a_asm_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[37:6] != 32'd0 |-> m_axis_tdata[2:0] == 3'(RES_OK))
        else $error("assembled length with failing status");
`endif

endmodule

FILE: hdl/tcr_cell.sv
// One table slot: compares against the new segment and shifts right on insert.
module tcr_cell
    import tcr_pkg::*;
(
    input  logic        clk,
    input  logic        valid,
    input  cmd_t        cmd,
    input  entry_t      left_entry,
    input  logic        less_left,
    input  logic        less_right,
    output entry_t      entry,
    output cell_flags_t flags
);

    entry_t            entry_reg;
    entry_t            entry_next;
    logic              less;
    logic [SEQ_W:0]    own_end;
    logic [SEQ_W:0]    new_end;

    assign less    = valid && (entry_reg.seq < cmd.seq);
    assign own_end = {1'b0, entry_reg.seq} + {{(SEQ_W+1-LEN_W){1'b0}}, entry_reg.len};
    assign new_end = {1'b0, cmd.seq} + {{(SEQ_W+1-LEN_W){1'b0}}, cmd.len};

    always_comb
    begin
        flags.less = less;
        // duplicate, predecessor running past new start, or new running past successor
        flags.ovl  = (valid && entry_reg.seq == cmd.seq)
                  || (less && !less_right && own_end > {1'b0, cmd.seq})
                  || (valid && !less && less_left && new_end > {1'b0, entry_reg.seq});
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins && !less)
        begin
            if (less_left)
                entry_next = '{seq: cmd.seq, len: cmd.len, tag: cmd.tag};
            else
                entry_next = left_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

FILE: hdl/tcr_chain.sv
// Sorted segment table of one direction, built as a row of cells.
module tcr_chain
    import tcr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output logic [CNT_W-1:0] count,
    output logic             ovl
);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    entry_t            entries [QUEUE_DEPTH];
    cell_flags_t       flags   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] ovl_vec;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            logic   lleft;
            logic   lright;
            entry_t lentry;
            logic   vld;
            if (g == 0)
            begin : g_first
                assign lleft  = 1'b1;
                assign lentry = '0;
            end
            else
            begin : g_mid
                assign lleft  = flags[g-1].less;
                assign lentry = entries[g-1];
            end
            if (g == QUEUE_DEPTH - 1)
            begin : g_last
                assign lright = 1'b0;
            end
            else
            begin : g_inner
                assign lright = flags[g+1].less;
            end
            assign vld = count_reg > CNT_W'(g);
            tcr_cell u_cell (
                .clk        (clk),
                .valid      (vld),
                .cmd        (cmd),
                .left_entry (lentry),
                .less_left  (lleft),
                .less_right (lright),
                .entry      (entries[g]),
                .flags      (flags[g])
            );
            assign ovl_vec[g] = flags[g].ovl;
        end
    endgenerate

    assign count_next = cmd.ins ? count_reg + CNT_W'(1) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign count = count_reg;
    assign ovl   = |ovl_vec;

`ifndef SYNTHESIS
    a_no_ins_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |-> count_reg < CNT_W'(QUEUE_DEPTH))
        else $error("insert into full table");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("count did not advance on insert");
    a_no_ins_ovl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |-> !ovl)
        else $error("insert despite overlap");
`endif

endmodule

FILE: tb/tb_tcp_connection_tracker_reassembly_unit.sv
// Self-checking testbench for the TCP connection tracker with reassembly tables.
module tb_tcp_connection_tracker_reassembly_unit;
    import tcr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        dir;
        logic [31:0] seq;
        logic        syn;
        logic        ack;
        logic        fin;
        logic        rst;
        logic        psh;
        logic [15:0] flen;
        logic [15:0] hlen;
        logic [15:0] tag;
    } segment_t;

    typedef struct {
        res_t        status;
        conn_t       state;
        logic [31:0] asm_len;
        logic [4:0]  count;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    tcp_connection_tracker_reassembly_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // tracker shadow state
    logic [31:0] floor_r [2];
    conn_t       trk_state;
    logic [31:0] tbl_seq [2][QUEUE_DEPTH];
    logic [15:0] tbl_len [2][QUEUE_DEPTH];
    logic [15:0] tbl_tag [2][QUEUE_DEPTH];
    int          tbl_used [2];
    logic [31:0] next_seq [2];
    logic [31:0] asm_bytes [2];

    segment_t    seg_q [$];
    verdict_t    verdict_q [$];
    logic [31:0] gen_cursor [2];
    int          idle_mode;
    int          err_cnt;
    int          checked_cnt;
    int          stored_cnt;
    logic        in_fire;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
        err_cnt++;
    endtask

    function automatic res_t table_insert(input segment_t s, output logic stored);
        int          n;
        int          pos;
        logic [15:0] size;
        logic [32:0] sum;
        n = tbl_used[s.dir];
        stored = 1'b0;
        if (s.hlen > s.flen)
            return RES_BADLEN;
        size = s.flen - s.hlen;
        if (size == 0)
            return RES_OK;
        if (n >= QUEUE_DEPTH)
            return RES_FULL;
        pos = 0;
        while (pos < n && tbl_seq[s.dir][pos] < s.seq)
            pos++;
        if (pos < n && tbl_seq[s.dir][pos] == s.seq)
            return RES_OVERLAP;
        if (pos > 0 && {1'b0, s.seq} <
            {1'b0, tbl_seq[s.dir][pos-1]} + {17'd0, tbl_len[s.dir][pos-1]})
            return RES_OVERLAP;
        if (pos < n && {1'b0, s.seq} + {17'd0, size} > {1'b0, tbl_seq[s.dir][pos]})
            return RES_OVERLAP;
        for (int i = n; i > pos; i--) begin
            tbl_seq[s.dir][i] = tbl_seq[s.dir][i-1];
            tbl_len[s.dir][i] = tbl_len[s.dir][i-1];
            tbl_tag[s.dir][i] = tbl_tag[s.dir][i-1];
        end
        tbl_seq[s.dir][pos] = s.seq;
        tbl_len[s.dir][pos] = size;
        tbl_tag[s.dir][pos] = s.tag;
        tbl_used[s.dir] = n + 1;
        if (next_seq[s.dir] == s.seq) begin
            sum = {1'b0, asm_bytes[s.dir]} + {17'd0, size};
            asm_bytes[s.dir] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            next_seq[s.dir] = s.seq + {16'd0, size};
        end
        stored = 1'b1;
        return RES_OK;
    endfunction

    function automatic verdict_t track_segment(input segment_t s);
        verdict_t v;
        logic     stored;
        stored = 1'b0;
        v.status = RES_OK;
        if (floor_r[s.dir] != 0 && s.seq <= floor_r[s.dir])
            v.status = RES_SEQ;
        else if (s.rst)
            v.status = RES_RST;
        else begin
            case (trk_state)
                ST_SYN:     if (s.dir && s.syn && s.ack) trk_state = ST_SYNACK;
                ST_SYNACK:  if (!s.dir && s.ack) trk_state = ST_EST;
                ST_EST:
                begin
                    if (s.fin) trk_state = ST_FIN1;
                    if (s.psh) v.status = table_insert(s, stored);
                end
                ST_FIN1:
                begin
                    if (s.ack) trk_state = ST_FIN1ACK;
                    if (s.fin) trk_state = ST_FIN2;
                    if (s.psh) v.status = table_insert(s, stored);
                end
                ST_FIN1ACK: if (s.fin) trk_state = ST_FIN2;
                ST_FIN2:    if (s.ack) trk_state = ST_CLOSE;
                ST_CLOSE:   v.status = RES_CLOSED;
                default:    ;
            endcase
        end
        if (stored) stored_cnt++;
        v.state   = trk_state;
        v.asm_len = stored ? asm_bytes[s.dir] : 32'd0;
        v.count   = tbl_used[s.dir][4:0];
        return v;
    endfunction

    // input accept and result check, sampled at the rising edge
    always @(posedge clk or negedge rst_n) begin
        verdict_t want;
        segment_t s;
        if (!rst_n) begin
            in_fire <= 1'b0;
        end
        else begin
            in_fire <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                s.dir  = s_axis_tuser;
                s.seq  = s_axis_tdata[31:0];
                s.syn  = s_axis_tdata[32];
                s.ack  = s_axis_tdata[33];
                s.fin  = s_axis_tdata[34];
                s.rst  = s_axis_tdata[35];
                s.psh  = s_axis_tdata[36];
                s.flen = s_axis_tdata[52:37];
                s.hlen = s_axis_tdata[68:53];
                s.tag  = s_axis_tdata[84:69];
                verdict_q.push_back(track_segment(s));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                checked_cnt++;
                if (verdict_q.size() == 0)
                    report("unexpected result word", m_axis_tdata[31:0], 32'd0);
                else begin
                    want = verdict_q.pop_front();
                    if (m_axis_tdata[2:0] !== want.status)
                        report("status", m_axis_tdata[2:0], want.status);
                    if (m_axis_tdata[5:3] !== want.state)
                        report("connection_state", m_axis_tdata[5:3], want.state);
                    if (m_axis_tdata[37:6] !== want.asm_len)
                        report("assembled_length", m_axis_tdata[37:6], want.asm_len);
                    if (m_axis_tdata[42:38] !== want.count)
                        report("entry_count", m_axis_tdata[42:38], want.count);
                end
            end
        end
    end

    // driver: changes inputs on the falling edge
    always @(negedge clk) begin
        segment_t s;
        if (rst_n) begin
            if (!s_axis_tvalid || in_fire) begin
                if (seg_q.size() > 0 &&
                    !((idle_mode == 1 && $urandom_range(0, 99) < 72) ||
                      (idle_mode == 3 && $urandom_range(0, 99) < 25))) begin
                    s = seg_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= s.dir;
                    s_axis_tdata  <= {3'b000, s.tag, s.hlen, s.flen,
                                      s.psh, s.rst, s.fin, s.ack, s.syn, s.seq};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= !((idle_mode == 2 && $urandom_range(0, 99) < 72) ||
                               (idle_mode == 3 && $urandom_range(0, 99) < 25));
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_FLOOR0: floor_r[0] = value;
            REG_FLOOR1: floor_r[1] = value;
            REG_START0: begin next_seq[0] = value; gen_cursor[0] = value; end
            REG_START1: begin next_seq[1] = value; gen_cursor[1] = value; end
            default:    ;
        endcase
    endtask

    task automatic add_seg(input logic dir, input logic [31:0] seq, input logic [4:0] flags,
                           input logic [15:0] flen, input logic [15:0] hlen);
        segment_t s;
        // flags from high to low: psh rst fin ack syn
        s.dir = dir;
        s.seq = seq;
        {s.psh, s.rst, s.fin, s.ack, s.syn} = flags;
        s.flen = flen;
        s.hlen = hlen;
        s.tag  = $urandom;
        seg_q.push_back(s);
    endtask

    // waits until every segment went out and every result came back
    task automatic drain();
        do @(negedge clk);
        while (seg_q.size() > 0 || s_axis_tvalid || verdict_q.size() > 0);
        repeat (4) @(negedge clk);
    endtask

    // random segments; in-order data dominates so the tables fill the proper way
    task automatic random_phase(input int n, input int fin_pct);
        segment_t s;
        int       pick;
        for (int k = 0; k < n; k++) begin
            s.dir  = $urandom_range(0, 1);
            s.psh  = $urandom_range(0, 99) < 90;
            s.rst  = $urandom_range(0, 99) < 3;
            s.syn  = $urandom_range(0, 1);
            s.ack  = $urandom_range(0, 1);
            s.fin  = $urandom_range(0, 99) < fin_pct;
            s.tag  = $urandom;
            pick   = $urandom_range(0, 99);
            if (pick < 5) begin
                s.flen = $urandom;
                s.hlen = $urandom;
            end
            else if (pick < 10) begin
                s.flen = $urandom_range(0, 60);
                s.hlen = s.flen + $urandom_range(1, 40);
            end
            else begin
                s.hlen = $urandom_range(0, 60);
                s.flen = s.hlen + $urandom_range(0, 200);
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                s.seq = gen_cursor[s.dir];
                if (s.flen > s.hlen)
                    gen_cursor[s.dir] = s.seq + (s.flen - s.hlen);
            end
            else if (pick < 80)
                s.seq = gen_cursor[s.dir] + $urandom_range(0, 400) - 200;
            else
                s.seq = $urandom;
            seg_q.push_back(s);
        end
    endtask

    initial begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b1;
        cfg_we        = 1'b0;
        cfg_index     = REG_FLOOR0;
        cfg_data      = '0;
        idle_mode     = 0;
        err_cnt       = 0;
        checked_cnt   = 0;
        stored_cnt    = 0;
        trk_state     = ST_SYN;
        floor_r       = '{default: '0};
        tbl_used      = '{default: 0};
        next_seq      = '{default: '0};
        asm_bytes     = '{default: '0};
        gen_cursor    = '{default: '0};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(REG_FLOOR0, 32'd0);
        write_reg(REG_FLOOR1, 32'd0);
        write_reg(REG_START0, 32'h0000_1000);
        write_reg(REG_START1, 32'hFFFF_FF00);

        // handshake, with noise in the opening states
        add_seg(0, 32'h0000_1000, 5'b10000, 16'd100, 16'd40);
        add_seg(1, 32'h0000_0000, 5'b00001, 16'd0, 16'd0);
        add_seg(1, 32'hFFFF_FFFF, 5'b01011, 16'hFFFF, 16'hFFFF);
        add_seg(1, 32'h5000_0000, 5'b00011, 16'd40, 16'd40);
        add_seg(1, 32'h5000_0001, 5'b00010, 16'd40, 16'd40);
        add_seg(0, 32'h0000_0FFF, 5'b00010, 16'd40, 16'd40);
        // established: in order, duplicate, both overlaps, empty, bad length
        add_seg(0, 32'h0000_1000, 5'b10000, 16'd100, 16'd40);
        add_seg(0, 32'h0000_1000, 5'b10000, 16'd50, 16'd40);
        add_seg(0, 32'h0000_1010, 5'b10000, 16'd50, 16'd40);
        add_seg(0, 32'h0000_0FFF, 5'b10000, 16'd60, 16'd0);
        add_seg(0, 32'h0000_0F00, 5'b10000, 16'd40, 16'd0);
        add_seg(0, 32'h0000_2000, 5'b10000, 16'd40, 16'd40);
        add_seg(0, 32'h0000_2000, 5'b10000, 16'd0, 16'hFFFF);
        add_seg(0, 32'h0000_103C, 5'b00000, 16'd80, 16'd20);
        add_seg(0, 32'h0000_103C, 5'b10000, 16'd80, 16'd20);
        add_seg(1, 32'hFFFF_FF00, 5'b10000, 16'hFFFF, 16'd0);
        add_seg(1, 32'hFFFF_FFFF, 5'b10000, 16'd10, 16'd0);
        add_seg(1, 32'h0000_FEFF, 5'b10000, 16'd30, 16'd10);
        add_seg(1, 32'h0000_0000, 5'b11000, 16'd30, 16'd10);
        drain();

        // floor checks: everything server side rejected, low client seqs rejected
        write_reg(REG_FLOOR0, 32'h0000_1040);
        write_reg(REG_FLOOR1, 32'hFFFF_FFFF);
        add_seg(0, 32'h0000_1040, 5'b10000, 16'd50, 16'd10);
        add_seg(0, 32'h0000_1041, 5'b10000, 16'd50, 16'd10);
        add_seg(1, 32'hFFFF_FFFF, 5'b10100, 16'd50, 16'd10);
        add_seg(1, 32'h0000_0001, 5'b01000, 16'd50, 16'd10);
        drain();

        write_reg(REG_FLOOR0, 32'd0);
        write_reg(REG_FLOOR1, 32'd0);
        for (int ph = 0; ph < 4; ph++) begin
            idle_mode = ph;
            random_phase(340, 0);
            drain();
            write_reg(REG_START0, $urandom);
            write_reg(REG_START1, $urandom_range(0, 1) ? 32'hFFFF_FFF0 : $urandom);
            write_reg(REG_FLOOR0, $urandom_range(0, 3) == 0 ? $urandom : 32'd0);
        end
        // closing sequence, then traffic against a closed connection
        idle_mode = 0;
        write_reg(REG_FLOOR0, 32'd0);
        random_phase(340, 15);
        drain();

        $display("Summary: %0d result words checked, %0d payloads stored, final state %s",
                 checked_cnt, stored_cnt, trk_state.name());
        $display("Covered handshake, floors, overlaps, full tables, idle/stall mixes, close");
        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #2ms;
        $display("Timeout with %0d results still expected", verdict_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
hdl/tcr_pkg.sv
hdl/tcr_cell.sv
hdl/tcr_chain.sv
hdl/tcp_connection_tracker_reassembly_unit.sv
tb/tb_tcp_connection_tracker_reassembly_unit.sv
